// ===== rtl/adts_pkg.sv =====
// Shared constants, types and the sample rate table for the ADTS deframer.
package adts_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 13;
   localparam int unsigned PTS_W    = 64;
   localparam int unsigned RATE_W   = 17;
   localparam int unsigned HDR_CNT_W = 3;
   localparam int unsigned HDR_BYTES = 7;

   // 1024 samples per frame times 1e6 us per second
   localparam int unsigned QUOT_W = 30;
   localparam logic [QUOT_W-1:0] FRAME_DIVIDEND = 30'd1024000000;

   localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'hFF;
   localparam logic [3:0]        SYNC_NIBBLE = 4'hF;
   localparam logic [LEN_W-1:0]  HDR_LEN     = 13'd7;
   localparam logic [RATE_W-1:0] DEFAULT_RATE = 17'd16000;

   typedef logic [BYTE_W-1:0] byte_type;

   // Sampling frequency index to rate in Hz; reserved codes give zero.
   function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
      logic [RATE_W-1:0] rate;
      case (idx)
         4'd0:    rate = 17'd96000;
         4'd1:    rate = 17'd88200;
         4'd2:    rate = 17'd64000;
         4'd3:    rate = 17'd48000;
         4'd4:    rate = 17'd44100;
         4'd5:    rate = 17'd32000;
         4'd6:    rate = 17'd24000;
         4'd7:    rate = 17'd22050;
         4'd8:    rate = 17'd16000;
         4'd9:    rate = 17'd12000;
         4'd10:   rate = 17'd11025;
         4'd11:   rate = 17'd8000;
         4'd12:   rate = 17'd7350;
         default: rate = '0;
      endcase
      return rate;
   endfunction

endpackage

// ===== rtl/adts_divider.sv =====
// Restoring divider, one quotient bit per cycle, of the frame duration by the rate.
module adts_divider
   import adts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RATE_W-1:0] divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(QUOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [RATE_W-1:0] dvs_ff, dvs_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [RATE_W:0]   trial;
   logic [RATE_W:0]   diff;

   assign trial = {rem_ff, FRAME_DIVIDEND[cnt_ff]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W - 1);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = diff[RATE_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[RATE_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== rtl/adts_frame_deframer_core.sv =====
// ADTS frame sync, header parse, frame pass-through and timestamp top level.
//
//   port group  direction  transfer condition       payload
//   req_        in         req_valid & !req_stall   data_byte
//   rsp_        out        rsp_valid & !rsp_stall   out_byte, frame_start, frame_end,
//                                                   frame_length, pts_us, header_error
//   csr_        in         csr_wr_en                fallback sample rate, 17 bits
//
// Sync and header bytes are taken one per cycle. The seventh header byte is followed by
// the header bytes as results (a single error result for a short length). Body bytes
// stream one per cycle while the result slot is free. At a frame end the divider produces
// one quotient bit per cycle, then the timestamp add and the final result follow.
// Reset is synchronous and returns the parser to sync hunt with a zero timestamp.
// A stalled result holds its register; input stalls while emitting, dividing or in a stalled body.
module adts_frame_deframer_core
   import adts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_frame_start,
   output logic              rsp_frame_end,
   output logic [LEN_W-1:0]  rsp_frame_length,
   output logic [PTS_W-1:0]  rsp_pts_us,
   output logic              rsp_header_error,
   input  logic              csr_wr_en,
   input  logic [RATE_W-1:0] csr_wr_data
);

   typedef enum logic [3:0] {
      S_HUNT,
      S_SYNC,
      S_HEADER,
      S_BODY,
      S_EMIT_ERR,
      S_EMIT_HDR,
      S_DIV_GO,
      S_DIV_WAIT,
      S_EMIT_END
   } state_type;

   state_type              state_ff, state_in;
   byte_type               hdr_ff [HDR_BYTES];
   byte_type               hdr_in [HDR_BYTES];
   logic [HDR_CNT_W-1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [HDR_CNT_W-1:0]   emit_idx_ff, emit_idx_in;
   logic [LEN_W-1:0]       remain_ff, remain_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [PTS_W-1:0]       pts_ff, pts_in;
   byte_type               end_byte_ff, end_byte_in;
   logic [RATE_W-1:0]      fallback_ff, fallback_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   byte_type               rsp_byte_ff, rsp_byte_in;
   logic                   rsp_start_ff, rsp_start_in;
   logic                   rsp_end_ff, rsp_end_in;
   logic [LEN_W-1:0]       rsp_len_ff, rsp_len_in;
   logic [PTS_W-1:0]       rsp_pts_ff, rsp_pts_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   accept;
   logic                   slot_free;
   logic [LEN_W-1:0]       parsed_len;
   logic [RATE_W-1:0]      table_rate;
   logic [RATE_W-1:0]      div_rate;
   logic                   div_start;
   logic                   div_done;
   logic [QUOT_W-1:0]      div_quot;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_HUNT) || (state_ff == S_SYNC) ||
                        (state_ff == S_HEADER) || ((state_ff == S_BODY) && slot_free));
   assign accept    = req_valid && !req_stall;

   assign parsed_len = {hdr_ff[3][1:0], hdr_ff[4], hdr_ff[5][7:5]};

   // Reserved index falls back to the configured rate, and zero to the default.
   assign table_rate = rate_lookup(hdr_ff[2][5:2]);
   always_comb begin
      if (table_rate != '0) begin
         div_rate = table_rate;
      end else if (fallback_ff != '0) begin
         div_rate = fallback_ff;
      end else begin
         div_rate = DEFAULT_RATE;
      end
   end

   assign div_start = (state_ff == S_DIV_GO);

   adts_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_rate),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in    = state_ff;
      hdr_in      = hdr_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      emit_idx_in = emit_idx_ff;
      remain_in   = remain_ff;
      len_in      = len_ff;
      pts_in      = pts_ff;
      end_byte_in = end_byte_ff;
      fallback_in = csr_wr_en ? csr_wr_data : fallback_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_pts_in   = rsp_pts_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         S_HUNT: begin
            if (accept && (req_data_byte == SYNC_BYTE)) begin
               hdr_in[0]  = req_data_byte;
               hdr_cnt_in = HDR_CNT_W'(1);
               state_in   = S_SYNC;
            end
         end
         S_SYNC: begin
            if (accept) begin
               if (req_data_byte[7:4] == SYNC_NIBBLE) begin
                  hdr_in[1]  = req_data_byte;
                  hdr_cnt_in = HDR_CNT_W'(2);
                  state_in   = S_HEADER;
               end else begin
                  hdr_cnt_in = '0;
                  state_in   = S_HUNT;
               end
            end
         end
         S_HEADER: begin
            if (accept) begin
               hdr_in[hdr_cnt_ff] = req_data_byte;
               if (hdr_cnt_ff == HDR_CNT_W'(HDR_BYTES - 1)) begin
                  hdr_cnt_in  = '0;
                  len_in      = parsed_len;
                  emit_idx_in = '0;
                  state_in    = (parsed_len < HDR_LEN) ? S_EMIT_ERR : S_EMIT_HDR;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 1'b1;
               end
            end
         end
         S_EMIT_ERR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_start_in = 1'b0;
               rsp_end_in   = 1'b0;
               rsp_len_in   = len_ff;
               rsp_pts_in   = '0;
               rsp_err_in   = 1'b1;
               remain_in    = '0;
               state_in     = S_HUNT;
            end
         end
         S_EMIT_HDR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hdr_ff[emit_idx_ff];
               rsp_start_in = (emit_idx_ff == '0);
               rsp_end_in   = 1'b0;
               rsp_len_in   = len_ff;
               rsp_pts_in   = '0;
               rsp_err_in   = 1'b0;
               emit_idx_in  = emit_idx_ff + 1'b1;
               if (emit_idx_ff == HDR_CNT_W'(HDR_BYTES - 2) && len_ff == HDR_LEN) begin
                  // header-only frame: last header byte closes the frame
                  end_byte_in = hdr_ff[HDR_BYTES-1];
                  remain_in   = '0;
                  state_in    = S_DIV_GO;
               end else if (emit_idx_ff == HDR_CNT_W'(HDR_BYTES - 1)) begin
                  remain_in = len_ff - HDR_LEN;
                  state_in  = S_BODY;
               end
            end
         end
         S_BODY: begin
            if (accept) begin
               if (remain_ff <= LEN_W'(1)) begin
                  end_byte_in = req_data_byte;
                  remain_in   = '0;
                  state_in    = S_DIV_GO;
               end else begin
                  remain_in    = remain_ff - 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = req_data_byte;
                  rsp_start_in = 1'b0;
                  rsp_end_in   = 1'b0;
                  rsp_len_in   = len_ff;
                  rsp_pts_in   = '0;
                  rsp_err_in   = 1'b0;
               end
            end
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               pts_in   = pts_ff + PTS_W'(div_quot);
               state_in = S_EMIT_END;
            end
         end
         S_EMIT_END: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = end_byte_ff;
               rsp_start_in = 1'b0;
               rsp_end_in   = 1'b1;
               rsp_len_in   = len_ff;
               rsp_pts_in   = pts_ff;
               rsp_err_in   = 1'b0;
               state_in     = S_HUNT;
            end
         end
         default: begin
            state_in = S_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_HUNT;
         hdr_cnt_ff   <= '0;
         emit_idx_ff  <= '0;
         remain_ff    <= '0;
         len_ff       <= '0;
         pts_ff       <= '0;
         fallback_ff  <= DEFAULT_RATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         emit_idx_ff  <= emit_idx_in;
         remain_ff    <= remain_in;
         len_ff       <= len_in;
         pts_ff       <= pts_in;
         fallback_ff  <= fallback_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hdr_ff       <= hdr_in;
      end_byte_ff  <= end_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_pts_ff   <= rsp_pts_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_frame_start  = rsp_start_ff;
   assign rsp_frame_end    = rsp_end_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_pts_us       = rsp_pts_ff;
   assign rsp_header_error = rsp_err_ff;

endmodule
